### hw/rtl/sle_pkg.sv
// Shared types and constants for the sequential list engine.
`default_nettype none

package sle_pkg;

  localparam int DEF_CAPACITY  = 8;
  localparam int DEF_NUM_LISTS = 2;

  localparam int CMD_W       = 3;
  localparam int LIST_ID_W   = 1;
  localparam int POS_W       = 4;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 4;
  localparam int MASK_W      = 8;
  localparam int IN_TUSER_W  = CMD_W + LIST_ID_W;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_AT   = 3'd1,
    CMD_INS_TAIL = 3'd2,
    CMD_REM_HEAD = 3'd3,
    CMD_REM_AT   = 3'd4,
    CMD_REM_TAIL = 3'd5,
    CMD_FIND     = 3'd6,
    CMD_CLEAR    = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Per-cycle action broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/sequential_list_engine.sv
// Top level: command decode, list counts, chain of list cells and result register.
// The result is registered and shows on out_tvalid in the cycle after the input transfer.
// Throughput: one command per cycle unless stalled; all entries move in one chain shift.
// Input is taken whenever the result register is empty or being drained.
// Reset (rst_n low, synchronous) empties all lists and drops any pending result;
// entry storage is not cleared and is read only below each list's count.
`default_nettype none

module sequential_list_engine #(
  parameter int CAPACITY  = sle_pkg::DEF_CAPACITY,
  parameter int NUM_LISTS = sle_pkg::DEF_NUM_LISTS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [3:0] position, [35:4] value, [39:36] zero
  input  wire logic [sle_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [2:0] command, [3] list_id
  input  wire logic [sle_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [1:0] status, [33:2] value_out, [37:34] count, [38] found,
  // [46:39] match_mask, [47] zero
  output logic      [sle_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int PW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int SW   = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int CMPW = (PW > sle_pkg::POS_W) ? PW : sle_pkg::POS_W;
  localparam int MW   = (CAPACITY < sle_pkg::MASK_W) ? CAPACITY : sle_pkg::MASK_W;
  localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

  // input fields
  sle_pkg::cmd_t                cmd;
  logic [sle_pkg::LIST_ID_W-1:0] list_id;
  logic [sle_pkg::POS_W-1:0]    pos;
  logic [sle_pkg::VALUE_W-1:0]  value;

  assign cmd     = sle_pkg::cmd_t'(in_tuser[sle_pkg::CMD_W-1:0]);
  assign list_id = in_tuser[sle_pkg::CMD_W +: sle_pkg::LIST_ID_W];
  assign pos     = in_tdata[sle_pkg::POS_W-1:0];
  assign value   = in_tdata[sle_pkg::POS_W +: sle_pkg::VALUE_W];

  logic in_xfer;
  logic out_valid_r;
  logic [sle_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  logic [SW-1:0] sel;
  assign sel = (NUM_LISTS > 1) ? SW'(list_id) : '0;

  logic [PW-1:0] counts_r   [NUM_LISTS];
  logic [PW-1:0] n;
  logic [CMPW-1:0] n_c, pos_c, at_c, n_new_c;
  assign n     = counts_r[sel];
  assign n_c   = CMPW'(n);
  assign pos_c = CMPW'(pos);

  // decode
  logic is_ins, is_rem, is_find, is_clr;
  logic ins_ok, rem_ok;
  sle_pkg::status_t status;

  always_comb begin
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    is_find = 1'b0;
    is_clr  = 1'b0;
    at_c    = pos_c;
    unique case (cmd)
      sle_pkg::CMD_INS_HEAD: begin
        is_ins = 1'b1;
        at_c   = '0;
      end
      sle_pkg::CMD_INS_AT: is_ins = 1'b1;
      sle_pkg::CMD_INS_TAIL: begin
        is_ins = 1'b1;
        at_c   = n_c;
      end
      sle_pkg::CMD_REM_HEAD: begin
        is_rem = 1'b1;
        at_c   = '0;
      end
      sle_pkg::CMD_REM_AT: is_rem = 1'b1;
      sle_pkg::CMD_REM_TAIL: begin
        is_rem = 1'b1;
        at_c   = n_c - CMPW'(1);
      end
      sle_pkg::CMD_FIND:  is_find = 1'b1;
      sle_pkg::CMD_CLEAR: is_clr  = 1'b1;
      default: is_clr = 1'b1;
    endcase
  end

  always_comb begin
    status = sle_pkg::ST_OK;
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    if (is_ins) begin
      if (n_c >= CAP_C) begin
        status = sle_pkg::ST_FULL;
      end else if (at_c > n_c) begin
        status = sle_pkg::ST_BADPOS;
      end else begin
        ins_ok = 1'b1;
      end
    end else if (is_rem) begin
      if (n_c == '0) begin
        status = sle_pkg::ST_EMPTY;
      end else if (at_c >= n_c) begin
        status = sle_pkg::ST_BADPOS;
      end else begin
        rem_ok = 1'b1;
      end
    end else if (is_find) begin
      if (n_c == '0) begin
        status = sle_pkg::ST_EMPTY;
      end
    end
  end

  always_comb begin
    n_new_c = n_c;
    if (is_clr) begin
      n_new_c = '0;
    end else if (ins_ok) begin
      n_new_c = n_c + CMPW'(1);
    end else if (rem_ok) begin
      n_new_c = n_c - CMPW'(1);
    end
  end

  // cell chain
  sle_pkg::cell_ctl_t           ctl;
  logic [sle_pkg::VALUE_W-1:0]  cell_word [CAPACITY];
  logic [CAPACITY-1:0]          hit;

  assign ctl.ins = in_xfer && ins_ok;
  assign ctl.rem = in_xfer && rem_ok;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [sle_pkg::VALUE_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = value;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = value;
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end

    sle_cell #(
      .CELL_IDX  (i),
      .NUM_LISTS (NUM_LISTS),
      .PW        (PW),
      .SW        (SW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .sel        (sel),
      .at         (at_c[PW-1:0]),
      .n          (n),
      .value      (value),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .hit        (hit[i])
    );
  end

  // result fields
  logic [sle_pkg::VALUE_W-1:0] value_out;
  logic                        found;
  logic [sle_pkg::MASK_W-1:0]  mask;

  always_comb begin
    if (rem_ok) begin
      value_out = cell_word[at_c[IW-1:0]];
    end else if (n_new_c == '0) begin
      value_out = '0;
    end else if (ins_ok && at_c == '0) begin
      value_out = value;
    end else begin
      value_out = cell_word[0];
    end
  end

  assign found = is_find && (|hit);
  assign mask  = is_find ? sle_pkg::MASK_W'(hit[MW-1:0]) : '0;

  // list counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LISTS; l++) begin
        counts_r[l] <= '0;
      end
    end else if (in_xfer) begin
      counts_r[sel] <= n_new_c[PW-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_tdata_r <= {1'b0, mask, found, n_new_c[sle_pkg::COUNT_W-1:0], value_out, status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_c <= CAP_C)
    else $error("list count above capacity");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && cmd == sle_pkg::CMD_CLEAR) |=> (out_tdata[37:34] == '0))
    else $error("clear did not empty the list");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == sle_pkg::ST_FULL) |->
      (out_tdata[37:34] == CAP_C[sle_pkg::COUNT_W-1:0]))
    else $error("full status with count below capacity");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == sle_pkg::ST_EMPTY) |->
      (out_tdata[46:38] == '0 && out_tdata[33:2] == '0))
    else $error("empty status with data or matches");

endmodule

`default_nettype wire

### hw/rtl/sle_cell.sv
// One list position: holds that entry of every list and shifts with its neighbors.
`default_nettype none

module sle_cell #(
  parameter int CELL_IDX  = 0,
  parameter int NUM_LISTS = sle_pkg::DEF_NUM_LISTS,
  parameter int PW        = 4,
  parameter int SW        = 1
) (
  input  wire logic                         clk,
  input  wire sle_pkg::cell_ctl_t           ctl,
  input  wire logic [SW-1:0]                sel,
  input  wire logic [PW-1:0]                at,
  input  wire logic [PW-1:0]                n,
  input  wire logic [sle_pkg::VALUE_W-1:0]  value,
  input  wire logic [sle_pkg::VALUE_W-1:0]  left_word,
  input  wire logic [sle_pkg::VALUE_W-1:0]  right_word,
  output logic      [sle_pkg::VALUE_W-1:0]  word,
  output logic                              hit
);

  localparam logic [PW-1:0] IDX    = PW'(CELL_IDX);
  localparam logic [PW-1:0] IDX_P1 = PW'(CELL_IDX + 1);

  logic [sle_pkg::VALUE_W-1:0] word_r   [NUM_LISTS];
  logic [sle_pkg::VALUE_W-1:0] word_nxt [NUM_LISTS];

  always_comb begin
    for (int l = 0; l < NUM_LISTS; l++) begin
      word_nxt[l] = word_r[l];
      if (SW'(l) == sel) begin
        if (ctl.ins) begin
          if (IDX == at) begin
            word_nxt[l] = value;
          end else if (IDX > at && IDX <= n) begin
            word_nxt[l] = left_word;
          end
        end else if (ctl.rem) begin
          // pull the upper neighbor down over the removed slot
          if (IDX >= at && IDX_P1 < n) begin
            word_nxt[l] = right_word;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_LISTS; l++) begin
      word_r[l] <= word_nxt[l];
    end
  end

  assign word = word_r[sel];
  assign hit  = (word == value) && (IDX < n);

endmodule

`default_nettype wire
